### src/dpf_pkg.sv
// Shared types and constants for the deduplicating packet FIFO.
// Used by dpf_ring, dpf_seq and the top level; depends on nothing else.
package dpf_pkg;

  localparam logic [1:0] REQ_ADD     = 2'd0;
  localparam logic [1:0] REQ_FORWARD = 2'd1;
  localparam logic [1:0] REQ_COUNT   = 2'd2;

  localparam int LIMIT_W = 11;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
  localparam logic [LIMIT_W-1:0] COUNT_MAX = 11'd2047;

  typedef struct packed {
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] ts;
  } pkt_t;

  typedef struct packed {
    logic               ok;
    logic [15:0]        src;
    logic [15:0]        dst;
    logic [31:0]        ts;
    logic [LIMIT_W-1:0] count;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FWD_READ,
    ST_FWD_TAKE,
    ST_DONE
  } state_t;

endpackage

### src/dpf_ring.sv
// Packet storage ring: one write port and one registered read port.
// Depends on dpf_pkg for the packet type.
module dpf_ring #(
  parameter int DEPTH = 1024,
  parameter int IW = 10
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [IW-1:0]   rd_addr,
  output dpf_pkg::pkt_t   rd_data,
  input  logic            wr_en,
  input  logic [IW-1:0]   wr_addr,
  input  dpf_pkg::pkt_t   wr_data
);
  import dpf_pkg::*;

  pkt_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/dpf_seq.sv
// Sequencer and shared compare unit that scan, append and pop ring entries.
// Depends on dpf_pkg; drives the ports of dpf_ring.
module dpf_seq #(
  parameter int DEPTH = 1024,
  parameter int IW = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   req_type,
  input  logic [15:0]                  source,
  input  logic [15:0]                  destination,
  input  logic [31:0]                  timestamp,
  input  logic [31:0]                  start_time,
  input  logic [31:0]                  end_time,
  input  logic [dpf_pkg::LIMIT_W-1:0]  memory_limit,
  input  logic                         out_free,
  output logic                         res_load,
  output dpf_pkg::result_t             res,
  output logic                         rd_en,
  output logic [IW-1:0]                rd_addr,
  input  dpf_pkg::pkt_t                rd_data,
  output logic                         wr_en,
  output logic [IW-1:0]                wr_addr,
  output dpf_pkg::pkt_t                wr_data
);
  import dpf_pkg::*;

  localparam int OW = $clog2(DEPTH + 1);
  localparam int SW = OW + 1;
  localparam int CW = ((OW > LIMIT_W) ? OW : LIMIT_W) + 1;

  function automatic logic [IW-1:0] wrap(input logic [SW-1:0] s);
    if (s >= SW'(DEPTH)) begin
      return IW'(s - SW'(DEPTH));
    end
    return IW'(s);
  endfunction

  state_t state, state_next;
  logic [IW-1:0] head;
  logic [OW-1:0] occ;
  logic [OW-1:0] cnt;
  logic vld;
  logic found;
  logic [1:0] req;
  pkt_t pkt;
  logic [31:0] lo, hi;

  logic accept;
  logic scan_more;
  logic scan_end;
  logic dup_hit;
  logic cnt_hit;
  logic full;
  logic [CW-1:0] lim;
  logic [IW-1:0] head1, head2;
  logic [OW-1:0] occ1;
  logic over;

  assign accept = in_valid && in_ready;
  assign scan_more = cnt < occ;
  assign scan_end = !scan_more && !vld;
  assign dup_hit = vld && (rd_data == pkt);
  assign cnt_hit = vld && (rd_data.dst == pkt.dst) && (rd_data.ts >= lo) && (rd_data.ts <= hi);

  assign full = occ >= OW'(DEPTH);
  assign lim = (CW'(memory_limit) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(memory_limit);
  assign head1 = full ? wrap(SW'(head) + SW'(1)) : head;
  assign occ1 = full ? occ : occ + OW'(1);
  assign over = CW'(occ1) > lim;
  assign head2 = over ? wrap(SW'(head1) + SW'(1)) : head1;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (req_type)
            REQ_ADD, REQ_COUNT: state_next = ST_SCAN;
            REQ_FORWARD: state_next = (occ != '0) ? ST_FWD_READ : ST_DONE;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          if (req == REQ_ADD && !found) begin
            state_next = ST_WRITE;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_WRITE: state_next = ST_DONE;
      ST_FWD_READ: state_next = ST_FWD_TAKE;
      ST_FWD_TAKE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en = 1'b0;
    rd_addr = wrap(SW'(head) + SW'(cnt));
    wr_en = 1'b0;
    wr_addr = wrap(SW'(head) + SW'(occ));
    wr_data = pkt;
    res_load = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: rd_en = scan_more;
      ST_WRITE: wr_en = 1'b1;
      ST_FWD_READ: begin
        rd_en = 1'b1;
        rd_addr = head;
      end
      ST_DONE: res_load = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head <= '0;
      occ <= '0;
      cnt <= '0;
      vld <= 1'b0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      vld <= rd_en && (state == ST_SCAN);
      if (accept) begin
        cnt <= '0;
        found <= 1'b0;
      end
      if (state == ST_SCAN) begin
        if (scan_more) begin
          cnt <= cnt + OW'(1);
        end
        if (req == REQ_ADD && dup_hit) begin
          found <= 1'b1;
        end
      end
      if (state == ST_WRITE) begin
        head <= head2;
        occ <= over ? occ1 - OW'(1) : occ1;
      end
      if (state == ST_FWD_TAKE) begin
        head <= wrap(SW'(head) + SW'(1));
        occ <= occ - OW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= req_type;
      pkt <= '{src: source, dst: destination, ts: timestamp};
      lo <= start_time;
      hi <= end_time;
      res <= '0;
    end
    if (state == ST_SCAN && req == REQ_COUNT && cnt_hit && res.count != COUNT_MAX) begin
      res.count <= res.count + LIMIT_W'(1);
    end
    if (state == ST_WRITE) begin
      res.ok <= 1'b1;
    end
    if (state == ST_FWD_TAKE) begin
      res.ok <= 1'b1;
      res.src <= rd_data.src;
      res.dst <= rd_data.dst;
      res.ts <= rd_data.ts;
    end
  end

endmodule

### src/dedup_packet_fifo_with_range_count.sv
// Top level of the deduplicating packet FIFO with range count.
// Depends on dpf_pkg, dpf_ring and dpf_seq.
//
// Requests arrive on the in_valid/in_ready channel; each transaction gives
// one result transaction on out_valid/out_ready. An add compares the packet
// against every stored entry, one ring read per cycle, then, unless it is a
// duplicate, appends it and drops the oldest entry when the occupancy passes
// memory_limit (capped at DEPTH). A count scans the stored entries the same
// way. A forward pops the oldest entry.
// After acceptance an add runs the scan, writes a new packet and then loads
// the result; a count runs the scan and loads the result. The scan length is
// set by the occupancy and the single read port of the ring. A forward reads
// the oldest entry, then takes it; an empty forward or an unused request type
// goes straight to the result. The next request can be taken in the cycle
// after the result is loaded; in_ready is high only with no request in work.
// The result sits in an output register, so a new request is taken while a
// finished result waits; a stalled receiver holds the next result inside the
// sequencer until the register is free.
// Reset empties the queue and sets memory_limit to 1024; the ring contents
// are not cleared, since only occupied entries are ever read.
// cfg_we writes cfg_data into memory_limit at once; write only while idle.
module dedup_packet_fifo_with_range_count #(
  parameter int DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [dpf_pkg::LIMIT_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  req_type,
  input  logic [15:0]                 source,
  input  logic [15:0]                 destination,
  input  logic [31:0]                 timestamp,
  input  logic [31:0]                 start_time,
  input  logic [31:0]                 end_time,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        ok,
  output logic [15:0]                 out_source,
  output logic [15:0]                 out_destination,
  output logic [31:0]                 out_timestamp,
  output logic [dpf_pkg::LIMIT_W-1:0] match_count
);
  import dpf_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [LIMIT_W-1:0] memory_limit;
  logic out_free;
  logic res_load;
  result_t res;
  logic rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  pkt_t rd_data, wr_data;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      memory_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      ok <= res.ok;
      out_source <= res.src;
      out_destination <= res.dst;
      out_timestamp <= res.ts;
      match_count <= res.count;
    end
  end

  dpf_seq #(
    .DEPTH(DEPTH),
    .IW(IW)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .source(source),
    .destination(destination),
    .timestamp(timestamp),
    .start_time(start_time),
    .end_time(end_time),
    .memory_limit(memory_limit),
    .out_free(out_free),
    .res_load(res_load),
    .res(res),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  dpf_ring #(
    .DEPTH(DEPTH),
    .IW(IW)
  ) u_ring (
    .clk(clk),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

endmodule

### dv/dedup_packet_fifo_with_range_count_tb.sv
// Self-checking testbench for dedup_packet_fifo_with_range_count.
// Runs a directed table, then random traffic; depends on dpf_pkg and the top level.
// Holds its own queue model to predict responses; typed directed vectors are checked against their table entry.
module dedup_packet_fifo_with_range_count_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dpf_pkg::*;

  localparam int DEPTH = 1024;
  localparam int WATCHDOG_CYCLES = 8 * (DEPTH + 8);
  localparam int N_RANDOM = 556;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [15:0] ID_MAX = 16'hFFFF;
  localparam logic [31:0] TS_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] ts;
    logic [31:0] lo;
    logic [31:0] hi;
  } request_t;

  typedef struct packed {
    logic               set_limit;
    logic [LIMIT_W-1:0] limit;
    request_t           rq;
    logic               typed;
    result_t            want;
  } vector_t;

  localparam result_t ZERO_RESULT = '0;
  localparam result_t OK_ONLY = '{1'b1, 16'h0, 16'h0, 32'h0, 11'd0};

  localparam int N_DIRECTED = 24;
  localparam vector_t DIRECTED [N_DIRECTED] = '{
    '{1'b0, 11'd0, '{REQ_FORWARD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b1, ZERO_RESULT},
    '{1'b0, 11'd0, '{REQ_COUNT, 16'h0, 16'h0, 32'h0, 32'h0, TS_MAX}, 1'b1, ZERO_RESULT},
    '{1'b0, 11'd0, '{REQ_UNUSED, ID_MAX, ID_MAX, TS_MAX, TS_MAX, TS_MAX}, 1'b1, ZERO_RESULT},
    '{1'b0, 11'd0, '{REQ_ADD, ID_MAX, ID_MAX, TS_MAX, 32'h0, 32'h0}, 1'b1, OK_ONLY},
    '{1'b0, 11'd0, '{REQ_ADD, ID_MAX, ID_MAX, TS_MAX, 32'h0, 32'h0}, 1'b1, ZERO_RESULT},
    '{1'b0, 11'd0, '{REQ_ADD, 16'h0, 16'h0, 32'h0, TS_MAX, TS_MAX}, 1'b1, OK_ONLY},
    '{1'b0, 11'd0, '{REQ_ADD, 16'h0, ID_MAX, 32'h0, 32'h0, 32'h0}, 1'b1, OK_ONLY},
    '{1'b0, 11'd0, '{REQ_COUNT, 16'h0, ID_MAX, 32'h0, 32'h0, TS_MAX}, 1'b1,
      '{1'b0, 16'h0, 16'h0, 32'h0, 11'd2}},
    '{1'b0, 11'd0, '{REQ_COUNT, 16'h0, ID_MAX, 32'h0, TS_MAX, 32'h0}, 1'b1, ZERO_RESULT},
    '{1'b0, 11'd0, '{REQ_COUNT, 16'h0, ID_MAX, 32'h0, TS_MAX, TS_MAX}, 1'b1,
      '{1'b0, 16'h0, 16'h0, 32'h0, 11'd1}},
    '{1'b0, 11'd0, '{REQ_COUNT, 16'h0, 16'h0, 32'h0, 32'h1, TS_MAX}, 1'b1, ZERO_RESULT},
    '{1'b0, 11'd0, '{REQ_FORWARD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
      '{1'b1, ID_MAX, ID_MAX, TS_MAX, 11'd0}},
    '{1'b0, 11'd0, '{REQ_FORWARD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b1, OK_ONLY},
    '{1'b1, 11'd0, '{REQ_ADD, 16'h1, 16'h2, 32'h3, 32'h0, 32'h0}, 1'b1, OK_ONLY},
    '{1'b0, 11'd0, '{REQ_FORWARD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b0, ZERO_RESULT},
    '{1'b0, 11'd0, '{REQ_ADD, 16'h1, 16'h2, 32'h3, 32'h0, 32'h0}, 1'b1, OK_ONLY},
    '{1'b0, 11'd0, '{REQ_FORWARD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b1, ZERO_RESULT},
    '{1'b1, 11'd1, '{REQ_ADD, 16'h1234, 16'h00A5, 32'h1000, 32'h0, 32'h0}, 1'b1, OK_ONLY},
    '{1'b0, 11'd0, '{REQ_ADD, 16'h1234, 16'h00A5, 32'h1001, 32'h0, 32'h0}, 1'b1, OK_ONLY},
    '{1'b0, 11'd0, '{REQ_ADD, 16'h1234, 16'h00A5, 32'h1001, 32'h0, 32'h0}, 1'b1, ZERO_RESULT},
    '{1'b0, 11'd0, '{REQ_ADD, 16'h1234, 16'h00A5, 32'h1000, 32'h0, 32'h0}, 1'b1, OK_ONLY},
    '{1'b0, 11'd0, '{REQ_COUNT, 16'h0, 16'h00A5, 32'h0, 32'h0, TS_MAX}, 1'b1,
      '{1'b0, 16'h0, 16'h0, 32'h0, 11'd1}},
    '{1'b1, 11'd2047, '{REQ_FORWARD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b0, ZERO_RESULT},
    '{1'b1, LIMIT_RESET, '{REQ_COUNT, 16'h0, 16'h0, 32'h0, 32'h0, TS_MAX}, 1'b1, ZERO_RESULT}
  };

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         req_type;
  logic [15:0]        source;
  logic [15:0]        destination;
  logic [31:0]        timestamp;
  logic [31:0]        start_time;
  logic [31:0]        end_time;
  logic               out_valid;
  logic               out_ready;
  logic               ok;
  logic [15:0]        out_source;
  logic [15:0]        out_destination;
  logic [31:0]        out_timestamp;
  logic [LIMIT_W-1:0] match_count;

  pkt_t               ring_copy [DEPTH];
  int unsigned        head_slot;
  int unsigned        stored;
  logic [LIMIT_W-1:0] limit_reg;
  result_t            pending_responses [$];

  bit quiet;
  int stall_left;
  int idle_cycles;
  int errors;
  int results_seen;
  int n_added, n_dup, n_fwd, n_empty, n_count, n_hits, n_limits;
  int unsigned peak;

  dedup_packet_fifo_with_range_count #(.DEPTH(DEPTH)) u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .source          (source),
    .destination     (destination),
    .timestamp       (timestamp),
    .start_time      (start_time),
    .end_time        (end_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .ok              (ok),
    .out_source      (out_source),
    .out_destination (out_destination),
    .out_timestamp   (out_timestamp),
    .match_count     (match_count)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic result_t compute_response(input request_t r);
    result_t     res;
    pkt_t        p;
    pkt_t        q;
    int unsigned lim;
    int unsigned hits;
    int unsigned i;
    bit          dup;
    res = '0;
    p = {r.src, r.dst, r.ts};
    case (r.kind)
      REQ_ADD: begin
        lim = (limit_reg > DEPTH) ? DEPTH : limit_reg;
        dup = 1'b0;
        for (i = 0; i < stored; i++) begin
          if (ring_copy[(head_slot + i) % DEPTH] == p) dup = 1'b1;
        end
        if (dup) begin
          n_dup++;
        end else begin
          if (stored >= DEPTH) begin
            head_slot = (head_slot + 1) % DEPTH;
            stored--;
          end
          ring_copy[(head_slot + stored) % DEPTH] = p;
          stored++;
          if (stored > lim) begin
            head_slot = (head_slot + 1) % DEPTH;
            stored--;
          end
          if (stored > peak) peak = stored;
          res.ok = 1'b1;
          n_added++;
        end
      end
      REQ_FORWARD: begin
        if (stored != 0) begin
          q = ring_copy[head_slot];
          head_slot = (head_slot + 1) % DEPTH;
          stored--;
          res.ok = 1'b1;
          res.src = q.src;
          res.dst = q.dst;
          res.ts = q.ts;
          n_fwd++;
        end else begin
          n_empty++;
        end
      end
      REQ_COUNT: begin
        hits = 0;
        for (i = 0; i < stored; i++) begin
          q = ring_copy[(head_slot + i) % DEPTH];
          if (q.dst == r.dst && q.ts >= r.lo && q.ts <= r.hi && hits < COUNT_MAX) hits++;
        end
        res.count = LIMIT_W'(hits);
        n_count++;
        if (hits != 0) n_hits++;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic request_t draw_request();
    request_t    r;
    pkt_t        p;
    int unsigned pick;
    logic [31:0] span;
    r.src = 16'($urandom);
    r.dst = 16'($urandom);
    r.ts = $urandom;
    r.lo = $urandom;
    r.hi = $urandom;
    p = '0;
    if (stored != 0) p = ring_copy[(head_slot + $urandom_range(0, stored - 1)) % DEPTH];
    pick = $urandom_range(0, 99);
    if (pick < 50) r.kind = REQ_ADD;
    else if (pick < 72) r.kind = REQ_FORWARD;
    else if (pick < 94) r.kind = REQ_COUNT;
    else r.kind = REQ_UNUSED;
    case (r.kind)
      REQ_ADD: begin
        pick = $urandom_range(0, 9);
        if (stored != 0 && pick < 3) begin
          {r.src, r.dst, r.ts} = p;
        end else if (stored != 0 && pick < 5) begin
          {r.src, r.dst, r.ts} = p ^ (64'd1 << $urandom_range(0, 63));
        end else begin
          if ($urandom_range(0, 1) != 0) r.src = 16'($urandom_range(0, 7));
          if ($urandom_range(0, 1) != 0) r.dst = 16'($urandom_range(0, 3));
          if ($urandom_range(0, 1) != 0) r.ts = $urandom_range(0, 15);
        end
      end
      REQ_COUNT: begin
        if (stored != 0 && $urandom_range(0, 9) < 7) r.dst = p.dst;
        else if ($urandom_range(0, 1) != 0) r.dst = 16'($urandom_range(0, 3));
        span = $urandom_range(0, 8);
        case ($urandom_range(0, 3))
          0: begin
            r.lo = 32'h0;
            r.hi = TS_MAX;
          end
          1: begin
            r.lo = (p.ts > span) ? p.ts - span : 32'h0;
            r.hi = (p.ts > TS_MAX - span) ? TS_MAX : p.ts + span;
          end
          2: begin
            r.lo = p.ts;
            r.hi = p.ts;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic drive_request(input request_t r, input bit typed, input result_t want);
    int      gap;
    result_t predicted;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r.kind;
    source <= r.src;
    destination <= r.dst;
    timestamp <= r.ts;
    start_time <= r.lo;
    end_time <= r.hi;
    do @(posedge clk); while (!in_ready);
    predicted = compute_response(r);
    pending_responses.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    limit_reg = value;
    n_limits++;
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      stall_left = quiet ? 0 : $urandom_range(0, 5);
      if (pending_responses.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = pending_responses.pop_front();
        if (ok !== want.ok)
          report_mismatch($sformatf("result %0d ok: got %0b, want %0b",
                                    results_seen, ok, want.ok));
        if (out_source !== want.src)
          report_mismatch($sformatf("result %0d out_source: got %0h, want %0h",
                                    results_seen, out_source, want.src));
        if (out_destination !== want.dst)
          report_mismatch($sformatf("result %0d out_destination: got %0h, want %0h",
                                    results_seen, out_destination, want.dst));
        if (out_timestamp !== want.ts)
          report_mismatch($sformatf("result %0d out_timestamp: got %0h, want %0h",
                                    results_seen, out_timestamp, want.ts));
        if (match_count !== want.count)
          report_mismatch($sformatf("result %0d match_count: got %0d, want %0d",
                                    results_seen, match_count, want.count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [LIMIT_W-1:0] lim;
    int                 k;
    int                 phase_len;
    int                 random_items;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = REQ_ADD;
    source = '0;
    destination = '0;
    timestamp = '0;
    start_time = '0;
    end_time = '0;
    out_ready = 1'b0;
    head_slot = 0;
    stored = 0;
    limit_reg = LIMIT_RESET;
    quiet = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    errors = 0;
    results_seen = 0;
    random_items = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (k = 0; k < N_DIRECTED; k++) begin
      if (DIRECTED[k].set_limit) set_limit(DIRECTED[k].limit);
      drive_request(DIRECTED[k].rq, DIRECTED[k].typed, DIRECTED[k].want);
    end

    while (random_items < N_RANDOM) begin
      case ($urandom_range(0, 7))
        0: lim = 11'd0;
        1: lim = 11'd1;
        2: lim = 11'd2;
        3, 4: lim = 11'($urandom_range(3, 12));
        5: lim = 11'($urandom_range(13, 64));
        6: lim = 11'd2047;
        default: lim = LIMIT_RESET;
      endcase
      set_limit(lim);
      quiet = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(15, 50);
      if (phase_len > N_RANDOM - random_items) phase_len = N_RANDOM - random_items;
      repeat (phase_len) begin
        drive_request(draw_request(), 1'b0, ZERO_RESULT);
        random_items++;
      end
    end

    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(negedge clk);
    repeat (DEPTH + 8) @(negedge clk);

    $display("run: %0d packets added, %0d duplicates rejected, %0d forwards, %0d empty forwards",
             n_added, n_dup, n_fwd, n_empty);
    $display("run: %0d counts (%0d nonzero), %0d limit settings, peak occupancy %0d",
             n_count, n_hits, n_limits, peak);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
